// ----- hw/rtl/vbc_pkg.sv -----
package vbc_pkg;

  // Default geometry
  localparam int XY_VOXEL_BITS = 9;
  localparam int Z_VOXELS      = 64;
  localparam int FRAC_BITS     = 4;

  // Largest geometry the command word carries
  localparam int XY_MAX = 12;
  localparam int Z_MAX  = 64;
  localparam int ZI_MAX = 6;

  // Port and datapath widths
  localparam int IN_W   = 72;
  localparam int OUT_W  = 40;
  localparam int CW     = 16;
  localparam int DW     = 24;
  localparam int SUM_W  = 48;
  localparam int MAG_W  = 16;
  localparam int NW     = 70;

  localparam logic [7:0] MARGIN_RST = 8'd16;

  // Kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // One classified item
  typedef struct packed {
    logic                     query;
    logic                     active;
    logic                     last;
    logic [XY_MAX-1:0]        x0;
    logic [XY_MAX-1:0]        x1;
    logic [XY_MAX-1:0]        y0;
    logic [XY_MAX-1:0]        y1;
    logic [ZI_MAX-1:0]        zidx;
    logic [Z_MAX-1:0]         zmask;
    logic signed [13:0]       px2;
    logic signed [13:0]       py2;
  } cmd_t;

  // Scan result handed to the normalizer
  typedef struct packed {
    logic                     hit;
    logic signed [SUM_W-1:0]  sumx;
    logic signed [SUM_W-1:0]  sumy;
  } job_t;

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                 input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- hw/rtl/vbc_front.sv -----
module vbc_front #(
  parameter int XY_VOXEL_BITS = vbc_pkg::XY_VOXEL_BITS,
  parameter int Z_VOXELS      = vbc_pkg::Z_VOXELS,
  parameter int FRAC_BITS     = vbc_pkg::FRAC_BITS
) (
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [vbc_pkg::IN_W-1:0] s_tdata,
  input  logic                     s_tuser,
  input  logic                     s_tlast,
  input  logic [7:0]               xy_margin,
  input  logic                     clearing,
  input  logic                     q_ready,
  output logic                     q_push,
  output vbc_pkg::cmd_t            q_cmd
);

  localparam int CW = vbc_pkg::CW;
  localparam logic signed [CW-1:0] GH   = CW'(1 << (XY_VOXEL_BITS - 1));
  localparam logic signed [CW-1:0] ZTOP = CW'(Z_VOXELS);
  localparam logic signed [CW-1:0] ZS   = CW'(3 << FRAC_BITS);

  logic signed [12:0] px, py;
  logic signed [10:0] pz;
  logic signed [CW-1:0] p2x, p2y, p2z, sxe, sye, sze, m2e;
  logic signed [CW-1:0] x0, x1, y0, y1, z0, z1;
  logic signed [CW-1:0] x0i, x1i, y0i, y1i, z0c, z1c;
  logic signed [CW-1:0] vx, vy, vz, vxi, vyi;
  logic covered, in_grid;
  logic [vbc_pkg::Z_MAX-1:0] zmask;

  assign px  = s_tdata[12:0];
  assign py  = s_tdata[25:13];
  assign pz  = s_tdata[36:26];
  assign sxe = CW'(s_tdata[47:37]);
  assign sye = CW'(s_tdata[58:48]);
  assign sze = CW'(s_tdata[69:59]);
  assign m2e = CW'({xy_margin, 1'b0});
  assign p2x = CW'(px) <<< 1;
  assign p2y = CW'(py) <<< 1;
  assign p2z = CW'(pz) <<< 1;

  // Box bounds in half units, floored to voxels
  assign x0 = (p2x - sxe - m2e) >>> (FRAC_BITS + 1);
  assign x1 = (p2x + sxe + m2e) >>> (FRAC_BITS + 1);
  assign y0 = (p2y - sye - m2e) >>> (FRAC_BITS + 1);
  assign y1 = (p2y + sye + m2e) >>> (FRAC_BITS + 1);
  assign z0 = (p2z - sze + ZS) >>> (FRAC_BITS + 1);
  assign z1 = (p2z + sze - ZS) >>> (FRAC_BITS + 1);

  assign covered = (x0 <= x1) && (y0 <= y1) && (z0 <= z1) &&
                   (x1 >= -GH) && (x0 < GH) && (y1 >= -GH) && (y0 < GH) &&
                   (z1 >= 0) && (z0 < ZTOP);

  // Clip to the grid and shift to unsigned indices
  assign x0i = vbc_pkg::clampc(x0, -GH, GH - 1) + GH;
  assign x1i = vbc_pkg::clampc(x1, -GH, GH - 1) + GH;
  assign y0i = vbc_pkg::clampc(y0, -GH, GH - 1) + GH;
  assign y1i = vbc_pkg::clampc(y1, -GH, GH - 1) + GH;
  assign z0c = vbc_pkg::clampc(z0, '0, ZTOP - 1);
  assign z1c = vbc_pkg::clampc(z1, '0, ZTOP - 1);

  assign zmask = ({vbc_pkg::Z_MAX{1'b1}} << z0c[vbc_pkg::ZI_MAX-1:0]) &
                 ({vbc_pkg::Z_MAX{1'b1}} >>
                  (vbc_pkg::ZI_MAX'(vbc_pkg::Z_MAX - 1) - z1c[vbc_pkg::ZI_MAX-1:0]));

  // Voxel of a map point
  assign vx  = CW'(px) >>> FRAC_BITS;
  assign vy  = CW'(py) >>> FRAC_BITS;
  assign vz  = CW'(pz) >>> FRAC_BITS;
  assign vxi = vx + GH;
  assign vyi = vy + GH;
  assign in_grid = (vx >= -GH) && (vx < GH) && (vy >= -GH) && (vy < GH) &&
                   (vz >= 0) && (vz < ZTOP);

  // Hold input while the queue is full or the map is being cleared
  assign s_tready = q_ready && !clearing;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd       = '0;
    q_cmd.query = (s_tuser == vbc_pkg::KIND_QUERY);
    q_cmd.last  = s_tlast;
    q_cmd.px2   = {px, 1'b0};
    q_cmd.py2   = {py, 1'b0};
    q_cmd.zmask = zmask;
    q_cmd.x1    = vbc_pkg::XY_MAX'(x1i[XY_VOXEL_BITS-1:0]);
    q_cmd.y1    = vbc_pkg::XY_MAX'(y1i[XY_VOXEL_BITS-1:0]);
    if (q_cmd.query) begin
      q_cmd.active = covered;
      q_cmd.x0     = vbc_pkg::XY_MAX'(x0i[XY_VOXEL_BITS-1:0]);
      q_cmd.y0     = vbc_pkg::XY_MAX'(y0i[XY_VOXEL_BITS-1:0]);
      q_cmd.zidx   = '0;
    end else begin
      q_cmd.active = in_grid;
      q_cmd.x0     = vbc_pkg::XY_MAX'(vxi[XY_VOXEL_BITS-1:0]);
      q_cmd.y0     = vbc_pkg::XY_MAX'(vyi[XY_VOXEL_BITS-1:0]);
      q_cmd.zidx   = vz[vbc_pkg::ZI_MAX-1:0];
    end
  end

endmodule

// ----- hw/rtl/vbc_queue.sv -----
module vbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vbc_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output vbc_pkg::cmd_t pop_cmd
);

  vbc_pkg::cmd_t slots [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       do_push, do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_cmd    = slots[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_cmd;
  end

endmodule

// ----- hw/rtl/vbc_back.sv -----
module vbc_back #(
  parameter int XY_VOXEL_BITS = vbc_pkg::XY_VOXEL_BITS,
  parameter int Z_VOXELS      = vbc_pkg::Z_VOXELS,
  parameter int FRAC_BITS     = vbc_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vbc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          clearing,
  output logic          job_valid,
  input  logic          job_ready,
  output vbc_pkg::job_t job
);

  localparam int AW    = 2 * XY_VOXEL_BITS;
  localparam int ZIW   = (Z_VOXELS > 1) ? $clog2(Z_VOXELS) : 1;
  localparam int NCW   = $clog2(Z_VOXELS + 1);
  localparam int CW    = vbc_pkg::CW;
  localparam int DW    = vbc_pkg::DW;
  localparam int SUM_W = vbc_pkg::SUM_W;
  localparam logic signed [CW-1:0] GH = CW'(1 << (XY_VOXEL_BITS - 1));

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_INS_RD = 3'd2;
  localparam logic [2:0] B_INS_WR = 3'd3;
  localparam logic [2:0] B_SCAN   = 3'd4;
  localparam logic [2:0] B_DRAIN  = 3'd5;
  localparam logic [2:0] B_SEND   = 3'd6;

  logic [2:0] state;
  vbc_pkg::cmd_t cmd;
  logic loaded, had;
  logic [AW-1:0] clr_cnt;
  logic [XY_VOXEL_BITS-1:0] cx, cy;

  logic [Z_VOXELS-1:0] occ [0:(1 << AW)-1];
  logic [Z_VOXELS-1:0] rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic rd_en, wr_en;

  logic signed [CW-1:0] xg, yg;
  logic signed [DW-1:0] offx, offy, dx1, dy1, dx2, dy2;
  logic v1, v2;
  logic [NCW-1:0] n2;
  logic signed [DW+NCW:0] mulx, muly;
  logic signed [SUM_W-1:0] prodx, prody, accx, accy;
  logic hitr;

  // Column store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) occ[waddr] <= wdata;
    if (rd_en) rdata <= occ[raddr];
  end

  assign rd_en = (state == B_SCAN) || (state == B_INS_RD);
  assign raddr = (state == B_SCAN) ? {cx, cy} :
                 {cmd.x0[XY_VOXEL_BITS-1:0], cmd.y0[XY_VOXEL_BITS-1:0]};
  assign wr_en = (state == B_CLEAR) || (state == B_INS_WR);
  assign waddr = (state == B_CLEAR) ? clr_cnt :
                 {cmd.x0[XY_VOXEL_BITS-1:0], cmd.y0[XY_VOXEL_BITS-1:0]};
  assign wdata = (state == B_CLEAR) ? '0 :
                 (rdata | (Z_VOXELS'(1) << cmd.zidx[ZIW-1:0]));

  assign clearing  = (state == B_CLEAR);
  assign q_pop     = (state == B_IDLE) && q_valid;
  assign job_valid = (state == B_SEND);
  assign job.hit   = hitr;
  assign job.sumx  = accx;
  assign job.sumy  = accy;

  // Centre offset of the voxel being read, in half units
  assign xg   = CW'(cx) - GH;
  assign yg   = CW'(cy) - GH;
  assign offx = DW'(cmd.px2) - (((DW'(xg) <<< 1) + DW'(1)) <<< FRAC_BITS);
  assign offy = DW'(cmd.py2) - (((DW'(yg) <<< 1) + DW'(1)) <<< FRAC_BITS);

  // Weight the offset by the voxel count, then widen for the sum
  assign mulx  = $signed({1'b0, n2}) * dx2;
  assign muly  = $signed({1'b0, n2}) * dy2;
  assign prodx = SUM_W'(mulx);
  assign prody = SUM_W'(muly);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      loaded  <= 1'b0;
      had     <= 1'b0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            if (q_cmd.query) begin
              cx <= q_cmd.x0[XY_VOXEL_BITS-1:0];
              cy <= q_cmd.y0[XY_VOXEL_BITS-1:0];
              state <= (loaded && q_cmd.active) ? B_SCAN : B_SEND;
            end else if (!loaded) begin
              had <= had || q_cmd.active;
              if (q_cmd.last && (had || q_cmd.active)) loaded <= 1'b1;
              if (q_cmd.active) state <= B_INS_RD;
            end
          end
        end
        B_INS_RD: state <= B_INS_WR;
        B_INS_WR: state <= B_IDLE;
        B_SCAN: begin
          if (cy == cmd.y1[XY_VOXEL_BITS-1:0]) begin
            cy <= cmd.y0[XY_VOXEL_BITS-1:0];
            if (cx == cmd.x1[XY_VOXEL_BITS-1:0]) state <= B_DRAIN;
            else cx <= cx + XY_VOXEL_BITS'(1);
          end else begin
            cy <= cy + XY_VOXEL_BITS'(1);
          end
        end
        B_DRAIN: begin
          if (!v1 && !v2) state <= B_SEND;
        end
        B_SEND: begin
          if (job_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Read, count and accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == B_SCAN);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= offx;
    dy1 <= offy;
    dx2 <= dx1;
    dy2 <= dy1;
    n2  <= NCW'($countones(rdata & cmd.zmask[Z_VOXELS-1:0]));
    if (state == B_IDLE) begin
      accx <= '0;
      accy <= '0;
      hitr <= 1'b0;
    end else if (v2) begin
      accx <= accx + prodx;
      accy <= accy + prody;
      if (n2 != '0) hitr <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/vbc_norm.sv -----
module vbc_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  vbc_pkg::job_t               job,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        hit,
  output logic [vbc_pkg::MAG_W-1:0]   push_x,
  output logic [vbc_pkg::MAG_W-1:0]   push_y,
  output logic                        push_valid
);

  localparam int SUM_W = vbc_pkg::SUM_W;
  localparam int MAG_W = vbc_pkg::MAG_W;
  localparam int NW    = vbc_pkg::NW;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_ABS   = 3'd1;
  localparam logic [2:0] N_SHIFT = 3'd2;
  localparam logic [2:0] N_SQ    = 3'd3;
  localparam logic [2:0] N_SUM   = 3'd4;
  localparam logic [2:0] N_STA   = 3'd5;
  localparam logic [2:0] N_STB   = 3'd6;
  localparam logic [2:0] N_OUT   = 3'd7;

  logic [2:0] state;
  logic hitj, pv;
  logic [3:0] b;
  logic [SUM_W-1:0] mag [2];
  logic neg [2];
  logic [2*MAG_W-1:0] sq [2];
  logic [2*MAG_W:0] s;
  logic [2*MAG_W:0] ssum;
  logic signed [NW-1:0] dd [2];
  logic signed [NW-1:0] ee [2];
  logic signed [NW-1:0] dc [2];
  logic signed [NW-1:0] ec [2];
  logic signed [NW-1:0] aa [2];
  logic [MAG_W-2:0] q [2];

  assign job_ready = (state == N_IDLE);
  assign ssum      = {1'b0, sq[0]} + {1'b0, sq[1]};

  // Digit-serial search for the rounded unit magnitude of each lane
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (job_valid) begin
            hitj   <= job.hit;
            mag[0] <= job.sumx;
            mag[1] <= job.sumy;
            neg[0] <= job.sumx[SUM_W-1];
            neg[1] <= job.sumy[SUM_W-1];
            q[0]   <= '0;
            q[1]   <= '0;
            pv     <= (job.sumx != '0) || (job.sumy != '0);
            state  <= ((job.sumx != '0) || (job.sumy != '0)) ? N_ABS : N_OUT;
          end
        end
        N_ABS: begin
          for (int l = 0; l < 2; l++) begin
            if (neg[l]) mag[l] <= SUM_W'(0) - mag[l];
          end
          state <= N_SHIFT;
        end
        N_SHIFT: begin
          if ((|mag[0][SUM_W-1:MAG_W]) || (|mag[1][SUM_W-1:MAG_W])) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
          end else begin
            state <= N_SQ;
          end
        end
        N_SQ: begin
          for (int l = 0; l < 2; l++) begin
            sq[l] <= mag[l][MAG_W-1:0] * mag[l][MAG_W-1:0];
          end
          state <= N_SUM;
        end
        N_SUM: begin
          s <= ssum;
          for (int l = 0; l < 2; l++) begin
            dd[l] <= NW'(ssum);
            ee[l] <= -NW'(ssum);
            aa[l] <= NW'(sq[l]) <<< 30;
          end
          b     <= 4'd14;
          state <= N_STA;
        end
        N_STA: begin
          for (int l = 0; l < 2; l++) begin
            dc[l] <= dd[l] + (ee[l] <<< ({1'b0, b} + 5'd2)) + (NW'(s) <<< (2 * b + 2));
            ec[l] <= ee[l] + (NW'(s) <<< ({1'b0, b} + 5'd1));
          end
          state <= N_STB;
        end
        N_STB: begin
          for (int l = 0; l < 2; l++) begin
            if (dc[l] <= aa[l]) begin
              dd[l]   <= dc[l];
              ee[l]   <= ec[l];
              q[l][b] <= 1'b1;
            end
          end
          if (b == 4'd0) begin
            state <= N_OUT;
          end else begin
            b     <= b - 4'd1;
            state <= N_STA;
          end
        end
        N_OUT: begin
          if (!m_tvalid || m_tready) state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  // Raise the result beat once loaded, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == N_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if ((state == N_OUT) && (!m_tvalid || m_tready)) begin
      hit        <= hitj;
      push_valid <= pv;
      push_x     <= neg[0] ? MAG_W'(0) - MAG_W'(q[0]) : MAG_W'(q[0]);
      push_y     <= neg[1] ? MAG_W'(0) - MAG_W'(q[1]) : MAG_W'(q[1]);
    end
  end

endmodule

// ----- hw/rtl/voxel_box_collision_query_core.sv -----
// In the executor an insert is a read-modify-write of one z-column word: a read, then a write.
// A query reads one column per covered xy voxel, one a cycle, then drains the read pipeline
// and hands its sums to the push normalizer (abs, shift, square, sum, then one bit per step;
// a zero sum skips to the output). A query before the map latches, or one covering nothing,
// goes straight to handoff. After rst the column store is cleared, one word a cycle, all
// 2^(2*XY_VOXEL_BITS) words (262144 by default); s_tready stays low until that pass is done.
module voxel_box_collision_query_core #(
  parameter int XY_VOXEL_BITS = vbc_pkg::XY_VOXEL_BITS,
  parameter int Z_VOXELS      = vbc_pkg::Z_VOXELS,
  parameter int FRAC_BITS     = vbc_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // pos_x[13], pos_y[13], pos_z[11], size_x[11], size_y[11], size_z[11], zero pad
  input  logic [vbc_pkg::IN_W-1:0]  s_tdata,
  // kind
  input  logic                      s_tuser,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // hit[1], push_x[16], push_y[16], zero pad
  output logic [vbc_pkg::OUT_W-1:0] m_tdata,
  // push_valid
  output logic                      m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data
);

  logic [7:0] xy_margin;
  logic clearing, q_ready, q_push, q_valid, q_pop;
  vbc_pkg::cmd_t f_cmd, b_cmd;
  logic job_valid, job_ready;
  vbc_pkg::job_t job;
  logic hit, push_valid;
  logic [vbc_pkg::MAG_W-1:0] push_x, push_y;

  // Margin register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) xy_margin <= vbc_pkg::MARGIN_RST;
    else if (cfg_valid) xy_margin <= cfg_data;
  end

  vbc_front #(
    .XY_VOXEL_BITS(XY_VOXEL_BITS), .Z_VOXELS(Z_VOXELS), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast), .xy_margin(xy_margin), .clearing(clearing), .q_ready(q_ready),
    .q_push(q_push), .q_cmd(f_cmd)
  );

  vbc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_cmd(f_cmd), .push_ready(q_ready),
    .pop(q_pop), .pop_valid(q_valid), .pop_cmd(b_cmd)
  );

  vbc_back #(
    .XY_VOXEL_BITS(XY_VOXEL_BITS), .Z_VOXELS(Z_VOXELS), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(b_cmd), .q_pop(q_pop),
    .clearing(clearing), .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  vbc_norm u_norm (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .hit(hit), .push_x(push_x),
    .push_y(push_y), .push_valid(push_valid)
  );

  assign m_tdata = {7'd0, push_y, push_x, hit};
  assign m_tuser = push_valid;

endmodule

// ----- hw/rtl/vbc_checker.sv -----
module vbc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [vbc_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);

  // No result beat right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // A push direction needs an occupied voxel
  a_push_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[0])
    else $error("push without hit");

  // No push direction means a zero vector
  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[32:1] == 32'd0)
    else $error("nonzero push marked invalid");

endmodule

bind voxel_box_collision_query_core vbc_checker u_vbc_checker (.*);
